FILE: src/osl_pkg.sv
// Shared types and constants for the occluded column span list.
`default_nettype none
package osl_pkg;

   localparam int COL_W = 12;
   localparam int VAL_W = 16;
   localparam int SCR_W = 13;

   localparam logic signed [VAL_W-1:0] LO_INF = -16'sd16384;
   localparam logic signed [VAL_W-1:0] HI_INF = 16'sd16383;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_SOLID = 2'd1;
   localparam logic [1:0] ACT_PASS  = 2'd2;

   typedef struct packed {
      logic signed [VAL_W-1:0] lo;
      logic signed [VAL_W-1:0] hi;
   } span_type;

   localparam span_type LEFT_SENTINEL = '{lo: LO_INF, hi: -16'sd1};

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ROT,
      OP_INS,
      OP_DROP,
      OP_CLEAR
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEEK,
      ST_MERGE,
      ST_ROTATE
   } state_type;

   typedef struct packed {
      cell_op_type op;
      span_type    tail;
      span_type    clear_hi;
   } chain_ctl_type;

endpackage
`default_nettype wire

FILE: src/occluded_column_span_list_core.sv
// Top level of the occluded column span list: sequencer, cell chain and result register.
// A clip item makes one full rotation of the chain, one cell per cycle unless a result
// stall holds it; a clear or ignored item is handled in the idle state. No new item is
// taken until the last one is done. Results leave through a one-word output register,
// one per cycle while the receiver keeps rsp_tready high.
// Reset (synchronous) loads the two sentinels with a screen width of 320.
`default_nettype none
module occluded_column_span_list_core
   import osl_pkg::*;
#(
   parameter int MAX_SPANS = 32,
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [SCR_W-1:0] csr_wr_data,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // [11:0] first_col, [23:12] last_col
   input  wire logic [23:0]      req_tdata,
   // [1:0] action
   input  wire logic [1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [11:0] frag_first, [23:12] frag_last
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tlast,
   // [0] overflow
   output logic                  rsp_tuser
);

   localparam int CW = $clog2(MAX_SPANS + 1);
   localparam int RW = $clog2(2 * MAX_SPANS + 1);
   localparam int RST_W = (MAX_WIDTH < 320) ? MAX_WIDTH : 320;
   localparam logic [SCR_W:0] MAX_W = (SCR_W + 1)'(MAX_WIDTH);

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         u_ff, u_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [COL_W-1:0]      f_ff, f_in, l_ff, l_in;
   logic                  ins_ff, ins_in;
   logic signed [VAL_W-1:0] plo_ff, plo_in, prev_ff, prev_in;
   logic [SCR_W-1:0]      screen_ff;

   logic                  rsp_valid_ff;
   logic [COL_W-1:0]      first_ff, last_ff;
   logic                  tlast_ff, ovf_ff;

   chain_ctl_type         ctl;
   span_type              cell_q [MAX_SPANS];
   span_type              h;

   logic                  accept, out_free, full;
   logic [1:0]            req_action;
   logic [COL_W-1:0]      req_first, req_last;
   logic signed [VAL_W-1:0] fv, lv, plo_s, hlo_m1, clear_lo;
   logic                  h_below, f_left, gap_before, l_inside, go_clip;

   logic                  emit, e_tlast, e_ovf;
   logic signed [VAL_W-1:0] e_first, e_last;

   assign req_action = req_tuser;
   assign req_first  = req_tdata[11:0];
   assign req_last   = req_tdata[23:12];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign go_clip    = (req_action == ACT_SOLID || req_action == ACT_PASS)
                       && (req_last >= req_first);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (cnt_ff == CW'(MAX_SPANS));

   assign h          = cell_q[0];
   assign fv         = $signed({{(VAL_W - COL_W){1'b0}}, f_ff});
   assign lv         = $signed({{(VAL_W - COL_W){1'b0}}, l_ff});
   assign hlo_m1     = h.lo - 16'sd1;
   assign h_below    = h.hi < (fv - 16'sd1);
   assign f_left     = fv < h.lo;
   assign gap_before = lv < hlo_m1;
   assign l_inside   = lv <= h.hi;
   assign plo_s      = (f_left && ins_ff) ? fv : h.lo;

   always_comb begin
      if (screen_ff == '0) begin
         clear_lo = 16'sd1;
      end else if ({1'b0, screen_ff} > MAX_W) begin
         clear_lo = $signed(VAL_W'(MAX_W));
      end else begin
         clear_lo = $signed(VAL_W'(screen_ff));
      end
   end

   // cell chain
   for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
      span_type nxt;
      if (i == MAX_SPANS - 1) begin : g_tail
         assign nxt = ctl.tail;
      end else begin : g_mid
         assign nxt = cell_q[i + 1];
      end
      osl_cell #(
         .IDX    (i),
         .UW     (CW),
         .RST_LO (RST_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .u       (u_ff),
         .next_in (nxt),
         .q       (cell_q[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && go_clip) begin
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (!h_below && !(f_left && !out_free)) begin
               if ((f_left && gap_before) || l_inside) begin
                  state_in = ST_ROTATE;
               end else begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            if (out_free && (gap_before || l_inside)) begin
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and chain control
   always_comb begin
      ctl.op       = OP_HOLD;
      ctl.tail     = h;
      ctl.clear_hi = '{lo: clear_lo, hi: HI_INF};
      cnt_in       = cnt_ff;
      u_in         = u_ff;
      f_in         = f_ff;
      l_in         = l_ff;
      ins_in       = ins_ff;
      plo_in       = plo_ff;
      prev_in      = prev_ff;
      emit         = 1'b0;
      e_first      = fv;
      e_last       = lv;
      e_tlast      = 1'b0;
      e_ovf        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               f_in   = req_first;
               l_in   = req_last;
               ins_in = (req_action == ACT_SOLID);
               u_in   = cnt_ff;
               if (req_action == ACT_CLEAR) begin
                  ctl.op = OP_CLEAR;
                  cnt_in = CW'(2);
               end
            end
         end
         ST_SEEK: begin
            if (h_below) begin
               ctl.op = OP_ROT;
               u_in   = u_ff - 1'b1;
            end else if (!(f_left && !out_free)) begin
               if (f_left && gap_before) begin
                  emit    = 1'b1;
                  e_tlast = 1'b1;
                  e_ovf   = ins_ff && full;
                  if (ins_ff && !full) begin
                     ctl.op   = OP_INS;
                     ctl.tail = '{lo: fv, hi: lv};
                     cnt_in   = cnt_ff + 1'b1;
                  end
               end else begin
                  emit    = f_left;
                  e_last  = hlo_m1;
                  e_tlast = l_inside;
                  if (l_inside) begin
                     ctl.op   = OP_ROT;
                     ctl.tail = '{lo: plo_s, hi: h.hi};
                     u_in     = u_ff - 1'b1;
                  end else begin
                     plo_in  = plo_s;
                     prev_in = h.hi;
                     u_in    = u_ff - 1'b1;
                     if (ins_ff) begin
                        ctl.op = OP_DROP;
                        cnt_in = cnt_ff - 1'b1;
                     end else begin
                        ctl.op = OP_ROT;
                     end
                  end
               end
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               emit    = 1'b1;
               e_first = prev_ff + 16'sd1;
               if (gap_before) begin
                  e_last  = lv;
                  e_tlast = 1'b1;
                  if (ins_ff) begin
                     ctl.op   = OP_INS;
                     ctl.tail = '{lo: plo_ff, hi: lv};
                     cnt_in   = cnt_ff + 1'b1;
                  end
               end else begin
                  e_last  = hlo_m1;
                  e_tlast = l_inside;
                  u_in    = u_ff - 1'b1;
                  if (l_inside) begin
                     ctl.op = OP_ROT;
                     if (ins_ff) begin
                        ctl.tail = '{lo: plo_ff, hi: h.hi};
                     end
                  end else begin
                     prev_in = h.hi;
                     if (ins_ff) begin
                        ctl.op = OP_DROP;
                        cnt_in = cnt_ff - 1'b1;
                     end else begin
                        ctl.op = OP_ROT;
                     end
                  end
               end
            end
         end
         ST_ROTATE: begin
            if (rem_ff != '0) begin
               ctl.op = OP_ROT;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      if (state_ff == ST_ROTATE) begin
         if (rem_ff != '0) begin
            rem_in = rem_ff - 1'b1;
         end
      end else if (state_in == ST_ROTATE) begin
         rem_in = RW'(u_in) + RW'(MAX_SPANS) - RW'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= CW'(2);
         u_ff         <= '0;
         rem_ff       <= '0;
         screen_ff    <= SCR_W'(320);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         u_ff     <= u_in;
         rem_ff   <= rem_in;
         if (csr_wr_en) begin
            screen_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      f_ff    <= f_in;
      l_ff    <= l_in;
      ins_ff  <= ins_in;
      plo_ff  <= plo_in;
      prev_ff <= prev_in;
      if (emit) begin
         first_ff <= e_first[COL_W-1:0];
         last_ff  <= e_last[COL_W-1:0];
         tlast_ff <= e_tlast;
         ovf_ff   <= e_ovf;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {last_ff, first_ff};
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = ovf_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff >= CW'(1) && cnt_ff <= CW'(MAX_SPANS))
      else $error("span count out of range");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_INS |-> cnt_ff < CW'(MAX_SPANS))
      else $error("insert into a full chain");

   a_emit_state: assert property (@(posedge clock) disable iff (reset)
      emit |-> (state_ff == ST_SEEK || state_ff == ST_MERGE) && out_free)
      else $error("fragment emitted outside a clip scan");

   a_idle_rot: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SEEK || state_ff == ST_MERGE))
      else $error("result raised outside a clip scan");
`endif

endmodule
`default_nettype wire

FILE: src/osl_cell.sv
// One cell of the span chain: holds a single span and shifts with its neighbour.
`default_nettype none
module osl_cell
   import osl_pkg::*;
#(
   parameter int IDX    = 0,
   parameter int UW     = 6,
   parameter int RST_LO = 320
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire chain_ctl_type ctl,
   input  wire logic [UW-1:0] u,
   input  wire span_type      next_in,
   output span_type           q
);

   localparam logic [UW-1:0] IDX_U = UW'(IDX);

   span_type q_ff;
   span_type q_in;

   always_comb begin
      q_in = q_ff;
      case (ctl.op)
         OP_ROT: begin
            q_in = next_in;
         end
         OP_INS: begin
            if (IDX_U >= u) begin
               q_in = next_in;
            end
         end
         OP_DROP: begin
            if (IDX_U < u) begin
               q_in = next_in;
            end
         end
         OP_CLEAR: begin
            if (IDX == 0) begin
               q_in = LEFT_SENTINEL;
            end else if (IDX == 1) begin
               q_in = ctl.clear_hi;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset && IDX == 0) begin
         q_ff <= LEFT_SENTINEL;
      end else if (reset && IDX == 1) begin
         q_ff <= '{lo: VAL_W'(RST_LO), hi: HI_INF};
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

FILE: tb/tb_occluded_column_span_list_core.sv
// Self-checking bench for the occluded column span list: random and directed clip traffic.
`default_nettype none
module tb_occluded_column_span_list_core
   import osl_pkg::*;
();

   localparam int SPAN_CAP = 32;
   localparam int FRAG_CAP = 32;
   localparam int WIDTH_CAP = 4096;
   localparam int QUIET_LIMIT = 20000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] first_col;
      logic [11:0] last_col;
      logic        is_cfg;
      logic [12:0] cfg_val;
   } stim_type;

   typedef struct packed {
      logic [11:0] frag_first;
      logic [11:0] frag_last;
      logic        last_of_run;
      logic        overflow;
   } frag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [SCR_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   occluded_column_span_list_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // occlusion list shadow
   longint occ_lo [SPAN_CAP];
   longint occ_hi [SPAN_CAP];
   int occ_n;
   int width_reg;

   stim_type pending_words [$];
   frag_type fragments_due [$];
   int errors = 0;
   int words_sent = 0;
   int frags_seen = 0;
   int ovf_seen = 0;
   bit hold_rx = 0;
   bit gate_tx = 0;
   int quiet = 0;
   int rx_gap = 0;

   task automatic report(input string what);
      errors++;
      $display("mismatch %0d: %s", errors, what);
   endtask

   function automatic void rebuild_list();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      occ_lo[0] = -64'sd2147483647;
      occ_hi[0] = -1;
      occ_lo[1] = w;
      occ_hi[1] = 64'sd2147483647;
      occ_n = 2;
   endfunction

   function automatic void add_frag(ref frag_type run[$], input longint a, input longint b,
                                    input bit ovf);
      frag_type fw;
      if (run.size() >= FRAG_CAP) return;
      fw.frag_first = a[11:0];
      fw.frag_last = b[11:0];
      fw.last_of_run = 1'b0;
      fw.overflow = ovf;
      run.push_back(fw);
   endfunction

   function automatic void squeeze(int s, int nx);
      int k;
      int d;
      if (nx == s || nx >= occ_n) return;
      d = nx - s;
      for (k = s + 1; k + d < occ_n; k++) begin
         occ_lo[k] = occ_lo[k + d];
         occ_hi[k] = occ_hi[k + d];
      end
      occ_n -= d;
   endfunction

   function automatic void clip_range(longint f, longint l, bit ins, ref frag_type run[$]);
      int s;
      int nx;
      int k;
      bit ovf;
      s = 0;
      while (s + 1 < occ_n && occ_hi[s] < f - 1) s++;
      if (f < occ_lo[s]) begin
         if (l < occ_lo[s] - 1) begin
            ovf = 0;
            if (ins) begin
               if (occ_n >= SPAN_CAP) ovf = 1;
               else begin
                  for (k = occ_n; k > s; k--) begin
                     occ_lo[k] = occ_lo[k - 1];
                     occ_hi[k] = occ_hi[k - 1];
                  end
                  occ_lo[s] = f;
                  occ_hi[s] = l;
                  occ_n++;
               end
            end
            add_frag(run, f, l, ovf);
            return;
         end
         add_frag(run, f, occ_lo[s] - 1, 0);
         if (ins) occ_lo[s] = f;
      end
      if (l <= occ_hi[s]) return;
      nx = s;
      while (nx + 1 < occ_n && l >= occ_lo[nx + 1] - 1) begin
         add_frag(run, occ_hi[nx] + 1, occ_lo[nx + 1] - 1, 0);
         nx++;
         if (l <= occ_hi[nx]) begin
            if (ins) begin
               occ_hi[s] = occ_hi[nx];
               squeeze(s, nx);
            end
            return;
         end
      end
      add_frag(run, occ_hi[nx] + 1, l, 0);
      if (ins) begin
         occ_hi[s] = l;
         squeeze(s, nx);
      end
   endfunction

   function automatic void predict_fragments(stim_type sw);
      frag_type run[$];
      if (sw.action == ACT_CLEAR) begin
         rebuild_list();
         return;
      end
      if (sw.action != ACT_SOLID && sw.action != ACT_PASS) return;
      if (sw.last_col < sw.first_col) return;
      clip_range(longint'(sw.first_col), longint'(sw.last_col), sw.action == ACT_SOLID, run);
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) fragments_due.push_back(run[i]);
   endfunction

   // driver
   int tx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         csr_wr_en <= 1'b0;
         if (req_tvalid && req_tready) words_sent++;
         if (!(req_tvalid && !req_tready)) begin
            if (tx_gap > 0 || gate_tx || pending_words.size() == 0) begin
               if (tx_gap > 0) tx_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words[0].is_cfg) begin
               // write only when idle
               req_tvalid <= 1'b0;
               if (fragments_due.size() == 0 && !(req_tvalid && req_tready)
                   && !rsp_tvalid && req_tready) begin
                  csr_wr_en <= 1'b1;
                  csr_wr_data <= pending_words[0].cfg_val;
                  width_reg = pending_words[0].cfg_val;
                  void'(pending_words.pop_front());
                  tx_gap = 40;
               end
            end else begin
               stim_type sw;
               sw = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {sw.last_col, sw.first_col};
               req_tuser <= sw.action;
               predict_fragments(sw);
               if ($urandom_range(0, 3) == 0)
                  tx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 3);
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            frag_type exp_w;
            frags_seen++;
            if (rsp_tuser) ovf_seen++;
            if (fragments_due.size() == 0) report("fragment with none expected");
            else begin
               exp_w = fragments_due.pop_front();
               if (rsp_tdata[11:0] !== exp_w.frag_first)
                  report($sformatf("frag_first %0d want %0d", rsp_tdata[11:0],
                                   exp_w.frag_first));
               if (rsp_tdata[23:12] !== exp_w.frag_last)
                  report($sformatf("frag_last %0d want %0d", rsp_tdata[23:12],
                                   exp_w.frag_last));
               if (rsp_tlast !== exp_w.last_of_run)
                  report($sformatf("last_of_run %0b want %0b", rsp_tlast,
                                   exp_w.last_of_run));
               if (rsp_tuser !== exp_w.overflow)
                  report($sformatf("overflow %0b want %0b", rsp_tuser, exp_w.overflow));
            end
         end
         if (hold_rx) rsp_tready <= 1'b0;
         else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 99) == 0) rx_gap = $urandom_range(20, 80);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_rx || reset
          || (pending_words.size() == 0 && fragments_due.size() == 0 && !req_tvalid))
         quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic stim_type clip_word(logic [1:0] act, int f, int l);
      stim_type sw;
      sw = '0;
      sw.action = act;
      sw.first_col = f[11:0];
      sw.last_col = l[11:0];
      return sw;
   endfunction

   function automatic stim_type cfg_word(int v);
      stim_type sw;
      sw = '0;
      sw.is_cfg = 1'b1;
      sw.cfg_val = v[12:0];
      return sw;
   endfunction

   task automatic load_random(int count, int span);
      int k;
      int f;
      int l;
      int r;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         f = $urandom_range(0, span);
         l = f + $urandom_range(0, span / 8 + 1);
         if (r < 3) pending_words.push_back(clip_word(ACT_CLEAR, $urandom, $urandom));
         else if (r < 5) pending_words.push_back(clip_word(ACT_UNUSED, $urandom, $urandom));
         else if (r < 8) pending_words.push_back(clip_word(ACT_SOLID, l + 1, f));
         else if (r < 11)
            pending_words.push_back(clip_word(ACT_PASS, $urandom_range(0, 4095),
                                              $urandom_range(0, 4095)));
         else if (r < 14) pending_words.push_back(clip_word(ACT_PASS, 0, 4095));
         else if (r < 70)
            pending_words.push_back(clip_word(ACT_SOLID, f, (l > 4095) ? 4095 : l));
         else pending_words.push_back(clip_word(ACT_PASS, f, (l > 4095) ? 4095 : l));
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || fragments_due.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   initial begin
      int k;
      int guard;
      width_reg = 320;
      rebuild_list();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed
      pending_words.push_back(clip_word(ACT_PASS, 0, 4095));
      pending_words.push_back(clip_word(ACT_SOLID, 10, 20));
      pending_words.push_back(clip_word(ACT_SOLID, 21, 25));
      pending_words.push_back(clip_word(ACT_SOLID, 5, 30));
      pending_words.push_back(clip_word(ACT_PASS, 0, 319));
      pending_words.push_back(clip_word(ACT_SOLID, 300, 4095));
      pending_words.push_back(clip_word(ACT_SOLID, 40, 39));
      pending_words.push_back(clip_word(ACT_UNUSED, 0, 100));
      pending_words.push_back(clip_word(ACT_SOLID, 0, 0));
      pending_words.push_back(clip_word(ACT_PASS, 0, 4095));
      pending_words.push_back(clip_word(ACT_CLEAR, 4095, 4095));
      pending_words.push_back(cfg_word(4096));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      pending_words.push_back(clip_word(ACT_PASS, 4095, 4095));
      // fill the list with isolated columns, then overflow it
      for (k = 0; k < 34; k++)
         pending_words.push_back(clip_word(ACT_SOLID, 4 * k + 2, 4 * k + 2));
      pending_words.push_back(clip_word(ACT_PASS, 0, 4095));
      pending_words.push_back(clip_word(ACT_SOLID, 0, 4095));
      pending_words.push_back(cfg_word(0));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      pending_words.push_back(clip_word(ACT_PASS, 0, 4095));
      pending_words.push_back(cfg_word(8191));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      pending_words.push_back(clip_word(ACT_PASS, 4000, 4095));
      pending_words.push_back(cfg_word(1));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      pending_words.push_back(clip_word(ACT_PASS, 0, 5));
      pending_words.push_back(cfg_word(320));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      wait_drained();

      // long receiver hold-off while input keeps coming
      load_random(30, 319);
      hold_rx = 1;
      repeat (600) @(posedge clock);
      hold_rx = 0;
      wait_drained();

      // sender pause until fully drained
      load_random(20, 319);
      repeat (150) @(posedge clock);
      gate_tx = 1;
      while (fragments_due.size() != 0 || req_tvalid) @(posedge clock);
      gate_tx = 0;

      load_random(150, 319);
      pending_words.push_back(cfg_word(4096));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      load_random(120, 4095);
      pending_words.push_back(cfg_word(64));
      pending_words.push_back(clip_word(ACT_CLEAR, 0, 0));
      load_random(100, 80);
      wait_drained();

      guard = 0;
      while (guard < 200) begin
         @(posedge clock);
         guard++;
      end
      $display("words accepted %0d, fragments checked %0d, overflow fragments %0d",
               words_sent, frags_seen, ovf_seen);
      if (errors == 0 && fragments_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
src/osl_pkg.sv
src/osl_cell.sv
src/occluded_column_span_list_core.sv
tb/tb_occluded_column_span_list_core.sv
